FILE: hdl/svc_pkg.sv
// ----------------------------------------------------------------------------
// Signed varint codec package
// Payload types, result codes and the encoding helpers shared by the front,
// the queue and the back end.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Operation codes of an input item.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Result kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // Encoded byte layout.
    localparam logic [7:0] CONT_BIT  = 8'h80;
    localparam logic [7:0] SIGN_BIT  = 8'h40;

    // Byte count thresholds.
    localparam logic [31:0] POS_LIM_1 = 32'h0000_0040;
    localparam logic [31:0] POS_LIM_2 = 32'h0000_2000;
    localparam logic [31:0] POS_LIM_3 = 32'h0010_0000;
    localparam logic [31:0] POS_LIM_4 = 32'h0800_0000;
    localparam logic [31:0] NEG_LIM_1 = 32'hFFFF_FFC0;
    localparam logic [31:0] NEG_LIM_2 = 32'hFFFF_E000;
    localparam logic [31:0] NEG_LIM_3 = 32'hFFF0_0000;
    localparam logic [31:0] NEG_LIM_4 = 32'hF800_0000;

    localparam logic [2:0] MAX_BYTES = 3'd5;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value_in;
        logic [7:0]         byte_in;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         byte_out;
        logic signed [31:0] value_out;
        logic               last;
    } t_out_item;

    // One queued job: a value to encode into nbytes bytes, or a decoded value.
    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [2:0]  nbytes;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Number of bytes the encoding of a value takes (1 to 5).
    function automatic logic [2:0] enc_len(input logic [31:0] u);
        logic [2:0] n;
        if (!u[31]) begin
            if (u < POS_LIM_1)      n = 3'd1;
            else if (u < POS_LIM_2) n = 3'd2;
            else if (u < POS_LIM_3) n = 3'd3;
            else if (u < POS_LIM_4) n = 3'd4;
            else                    n = MAX_BYTES;
        end else begin
            // Strictly above the limit, so -64 itself needs two bytes.
            if (u > NEG_LIM_1)      n = 3'd1;
            else if (u > NEG_LIM_2) n = 3'd2;
            else if (u > NEG_LIM_3) n = 3'd3;
            else if (u > NEG_LIM_4) n = 3'd4;
            else                    n = MAX_BYTES;
        end
        return n;
    endfunction

    // Byte k of the encoding of u, which takes n bytes in all.
    function automatic logic [7:0] enc_byte(input logic [31:0] u, input logic [2:0] k,
                                            input logic [2:0] n);
        logic [7:0] b;
        logic [2:0] k_next;
        k_next = k + 3'd1;
        case (k)
            3'd0:    b = {1'b0, u[31], u[5:0]};
            3'd1:    b = {1'b0, u[12:6]};
            3'd2:    b = {1'b0, u[19:13]};
            3'd3:    b = {1'b0, u[26:20]};
            3'd4:    b = {4'b0000, u[30:27]};
            default: b = 8'h00;
        endcase
        if (k_next < n) begin
            b = b | CONT_BIT;
        end
        return b;
    endfunction

    // Bits forced to one in a negative value after idx bytes.
    function automatic logic [31:0] fill_mask(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            3'd1:    m = 32'hFFFF_FFC0;
            3'd2:    m = 32'hFFFF_E000;
            3'd3:    m = 32'hFFF0_0000;
            3'd4:    m = 32'hF800_0000;
            3'd5:    m = 32'h8000_0000;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/signed_varint_codec.sv
// ----------------------------------------------------------------------------
// Signed varint codec
// Encodes 32-bit signed values into 1 to 5 bytes and decodes such bytes back.
//
// Input channel (i_valid, o_stall, i_item): one transaction is either a value
// to encode or one byte to decode. The input side takes one transaction per
// cycle while the job queue has room.
// Output channel (o_valid, i_stall, o_item): one transaction per result. An
// encode yields 1 to 5 byte results, the final one with last set; a decode
// byte yields a result only when it ends a value.
// An accepted job is written into the queue and reaches the output register
// from its head. The back end emits one result per cycle while the receiver
// does not stall, and an encode job stays at the head until its last byte.
// Reset clears the decoder state, the queue and the output valid flag.
// When the receiver stalls, the output register holds its result, the queue
// fills, and o_stall rises once QUEUE_DEPTH jobs are waiting.
// ----------------------------------------------------------------------------
module signed_varint_codec #(
    parameter int QUEUE_DEPTH = svc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  svc_pkg::t_in_item   i_item,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output svc_pkg::t_out_item  o_item
);

    logic               w_push;
    logic               w_pop;
    svc_pkg::t_cmd      w_cmd;
    svc_pkg::t_cmd      w_head;
    svc_pkg::t_q_status w_q_status;

    svc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_q_status (w_q_status),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    svc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    svc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .i_stall    (i_stall),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

    // The front end never writes a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("job pushed into full queue");

    // The back end never takes a job from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("job popped from empty queue");

    // A decoded value is always the only result of its transaction.
    a_value_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind == svc_pkg::KIND_VALUE) |-> o_item.last)
        else $error("decoded value without last");

    // An encoded byte carries its continue flag exactly when more bytes follow.
    a_cont_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind == svc_pkg::KIND_BYTE) |-> (o_item.byte_out[7] == !o_item.last))
        else $error("continue flag disagrees with last");

endmodule

FILE: hdl/svc_front.sv
// ----------------------------------------------------------------------------
// Signed varint codec front end
// Accepts input items, sizes encode jobs and gathers decode bytes; queues a
// job for every encode item and for every byte that ends a value.
// ----------------------------------------------------------------------------
module svc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  svc_pkg::t_in_item   i_item,
    input  svc_pkg::t_q_status  i_q_status,
    output logic                o_stall,
    output logic                o_push,
    output svc_pkg::t_cmd       o_cmd
);

    logic [31:0] r_accum;
    logic [2:0]  r_bytes_seen;
    logic        r_neg;
    logic [31:0] n_accum;
    logic [2:0]  n_bytes_seen;
    logic        n_neg;

    logic        accept;
    logic        start;
    logic [2:0]  idx;
    logic [31:0] gathered;
    logic        neg;
    logic        done;
    logic [7:0]  b;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign b       = i_item.byte_in;

    always_comb begin
        start    = (r_bytes_seen == 3'd0) || (r_bytes_seen > 3'd4);
        gathered = r_accum;
        neg      = r_neg;
        idx      = r_bytes_seen + 3'd1;
        if (start) begin
            gathered = {26'd0, b[5:0]};
            neg      = b[6];
            idx      = 3'd1;
        end else begin
            case (r_bytes_seen)
                3'd1:    gathered = r_accum | {19'd0, b[6:0], 6'd0};
                3'd2:    gathered = r_accum | {12'd0, b[6:0], 13'd0};
                3'd3:    gathered = r_accum | {5'd0, b[6:0], 20'd0};
                3'd4:    gathered = r_accum | {b[4:0], 27'd0};
                default: gathered = r_accum;
            endcase
        end
        done = !b[7] || (idx >= svc_pkg::MAX_BYTES);
    end

    always_comb begin
        n_accum      = r_accum;
        n_bytes_seen = r_bytes_seen;
        n_neg        = r_neg;
        o_push       = 1'b0;
        o_cmd.kind   = svc_pkg::KIND_BYTE;
        o_cmd.value  = i_item.value_in;
        o_cmd.nbytes = svc_pkg::enc_len(i_item.value_in);
        if (accept) begin
            if (i_item.op == svc_pkg::OP_ENCODE) begin
                o_push = 1'b1;
            end else if (done) begin
                o_push       = 1'b1;
                o_cmd.kind   = svc_pkg::KIND_VALUE;
                o_cmd.value  = neg ? (gathered | svc_pkg::fill_mask(idx)) : gathered;
                o_cmd.nbytes = 3'd1;
                n_accum      = 32'd0;
                n_bytes_seen = 3'd0;
                n_neg        = 1'b0;
            end else begin
                n_accum      = gathered;
                n_bytes_seen = idx;
                n_neg        = neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= 32'd0;
            r_bytes_seen <= 3'd0;
            r_neg        <= 1'b0;
        end else begin
            r_accum      <= n_accum;
            r_bytes_seen <= n_bytes_seen;
            r_neg        <= n_neg;
        end
    end

endmodule

FILE: hdl/svc_queue.sv
// ----------------------------------------------------------------------------
// Signed varint codec job queue
// A short first-in first-out store of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module svc_queue #(
    parameter int DEPTH = svc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  svc_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output svc_pkg::t_cmd       o_head,
    output svc_pkg::t_q_status  o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    svc_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == CNT_W'(0));
    assign o_status.full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: hdl/svc_back.sv
// ----------------------------------------------------------------------------
// Signed varint codec back end
// Takes jobs from the queue and, unless stalled, emits one result a cycle into
// the output register: the bytes of an encode job in order, or a decoded value.
// ----------------------------------------------------------------------------
module svc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svc_pkg::t_cmd       i_head,
    input  svc_pkg::t_q_status  i_q_status,
    input  logic                i_stall,
    output logic                o_pop,
    output logic                o_valid,
    output svc_pkg::t_out_item  o_item
);

    logic               r_out_valid;
    svc_pkg::t_out_item r_out;
    logic [2:0]         r_idx;
    logic               n_out_valid;
    svc_pkg::t_out_item n_out;
    logic [2:0]         n_idx;

    logic               load;
    logic               is_last;
    logic [2:0]         idx_next;

    assign o_valid  = r_out_valid;
    assign o_item   = r_out;
    assign load     = !r_out_valid || !i_stall;
    assign idx_next = r_idx + 3'd1;
    assign is_last  = (idx_next >= i_head.nbytes);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = !i_q_status.empty;
            if (!i_q_status.empty) begin
                n_out.kind = i_head.kind;
                if (i_head.kind == svc_pkg::KIND_VALUE) begin
                    n_out.byte_out  = 8'h00;
                    n_out.value_out = i_head.value;
                    n_out.last      = 1'b1;
                    o_pop           = 1'b1;
                    n_idx           = 3'd0;
                end else begin
                    n_out.byte_out  = svc_pkg::enc_byte(i_head.value, r_idx, i_head.nbytes);
                    n_out.value_out = 32'sd0;
                    n_out.last      = is_last;
                    o_pop           = is_last;
                    n_idx           = is_last ? 3'd0 : idx_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

endmodule

FILE: tb/sv/signed_varint_codec_tb.sv
// ----------------------------------------------------------------------------
// Signed varint codec testbench
// Drives encode values and decode bytes through the input channel. A
// scoreboard predicts every byte and decoded value from its own copy of the
// decoder state and checks the output channel in order. Both sides idle in
// random bursts, and the receiver holds off once for long enough to fill the
// job queue.
// ----------------------------------------------------------------------------
module signed_varint_codec_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS      = 170;
    localparam int TAIL_ITEMS   = 30;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    localparam logic [31:0] EDGE_VALUES [18] = '{
        32'h0000_0000, 32'h0000_003F, 32'h0000_0040, 32'hFFFF_FFC1,
        32'hFFFF_FFC0, 32'h0000_1FFF, 32'h0000_2000, 32'hFFFF_E001,
        32'hFFFF_E000, 32'h000F_FFFF, 32'h0010_0000, 32'hFFF0_0000,
        32'h07FF_FFFF, 32'h0800_0000, 32'hF800_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF
    };

    class varint_scoreboard;
        svc_pkg::t_out_item expected_q[$];
        int                 mismatches = 0;
        logic [31:0]        dec_accum  = '0;
        logic [2:0]         dec_count  = '0;
        logic               dec_neg    = 1'b0;

        // Bytes of one value, first byte first, continue flag on all but the last.
        function void encode_bytes(input logic [31:0] u, output logic [7:0] bytes[$]);
            int         sv;
            int         n;
            logic [7:0] b;
            sv = signed'(u);
            bytes = {};
            if (sv >= 0) begin
                n = (sv < 64) ? 1 : (sv < 8192) ? 2 : (sv < 1048576) ? 3 :
                    (sv < 134217728) ? 4 : 5;
            end else begin
                // Strictly above each limit, so -64 already needs two bytes.
                n = (sv > -64) ? 1 : (sv > -8192) ? 2 : (sv > -1048576) ? 3 :
                    (sv > -134217728) ? 4 : 5;
            end
            for (int k = 0; k < n; k++) begin
                case (k)
                    0:       b = {1'b0, u[31], u[5:0]};
                    4:       b = {4'h0, u[30:27]};
                    default: b = {1'b0, u[6 + 7 * (k - 1) +: 7]};
                endcase
                if (k < n - 1) begin
                    b = b | svc_pkg::CONT_BIT;
                end
                bytes.push_back(b);
            end
        endfunction

        function void note_input(input svc_pkg::t_in_item it);
            logic [7:0]         bytes[$];
            logic [31:0]        v;
            logic [31:0]        fill;
            svc_pkg::t_out_item r;
            if (it.op == svc_pkg::OP_ENCODE) begin
                encode_bytes(it.value_in, bytes);
                foreach (bytes[k]) begin
                    r.kind      = svc_pkg::KIND_BYTE;
                    r.byte_out  = bytes[k];
                    r.value_out = '0;
                    r.last      = (k == bytes.size() - 1);
                    expected_q.push_back(r);
                end
            end else begin
                if (dec_count == 3'd0 || dec_count > 3'd4) begin
                    dec_neg   = it.byte_in[6];
                    dec_accum = {26'd0, it.byte_in[5:0]};
                    dec_count = 3'd1;
                end else begin
                    dec_accum = dec_accum |
                                ({25'd0, it.byte_in[6:0]} << (6 + 7 * (dec_count - 1)));
                    dec_count = dec_count + 3'd1;
                end
                // The fifth byte closes the value whatever its continue flag says.
                if (!it.byte_in[7] || dec_count >= 3'd5) begin
                    v = dec_accum;
                    if (dec_neg) begin
                        // After five bytes only the sign bit is left to force.
                        fill = (dec_count == 3'd5) ? 32'h8000_0000 :
                               (32'hFFFF_FFFF << (6 + 7 * (dec_count - 1)));
                        v = v | fill;
                    end
                    r.kind      = svc_pkg::KIND_VALUE;
                    r.byte_out  = '0;
                    r.value_out = v;
                    r.last      = 1'b1;
                    expected_q.push_back(r);
                    dec_accum = '0;
                    dec_count = '0;
                    dec_neg   = 1'b0;
                end
            end
        endfunction

        function void check_result(input svc_pkg::t_out_item got);
            svc_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result kind %0d byte %02h value %08h last %0d",
                             $time, got.kind, got.byte_out, got.value_out, got.last);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
                got.value_out !== want.value_out || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: expected kind %0d byte %02h value %08h last %0d",
                             $time, want.kind, want.byte_out, want.value_out, want.last);
                    $display("%0t:      got kind %0d byte %02h value %08h last %0d",
                             $time, got.kind, got.byte_out, got.value_out, got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    svc_pkg::t_in_item  i_item;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall;
    svc_pkg::t_out_item o_item;

    varint_scoreboard  codec_sb = new;
    svc_pkg::t_in_item stim_q[$];
    int                n_directed;
    bit                pacing_on    = 1'b1;
    bit                hold_req     = 1'b0;
    bit                sink_holding = 1'b0;

    signed_varint_codec uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        // A random shift spreads the values over every encoded length.
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
            v = ~v;
        end
        return v;
    endfunction

    task automatic push_encode(input logic [31:0] v);
        svc_pkg::t_in_item it;
        it.op       = svc_pkg::OP_ENCODE;
        it.value_in = v;
        it.byte_in  = 8'($urandom);
        stim_q.push_back(it);
    endtask

    task automatic push_decode(input logic [7:0] b);
        svc_pkg::t_in_item it;
        it.op       = svc_pkg::OP_DECODE;
        it.value_in = 32'($urandom);
        it.byte_in  = b;
        stim_q.push_back(it);
    endtask

    task automatic build_stimulus();
        logic [7:0] seq[$];
        int         r;
        int         cut;
        foreach (EDGE_VALUES[k]) begin
            push_encode(EDGE_VALUES[k]);
        end
        // One-byte negative value, then a five-byte run whose last byte keeps
        // its continue flag, with an encode slipped into the middle of it.
        push_decode(8'h7F);
        push_decode(8'hFF);
        push_decode(8'hFF);
        push_encode(32'h0000_55AA);
        push_decode(8'hFF);
        push_decode(8'hFF);
        push_decode(8'hFF);
        n_directed = stim_q.size();

        while (stim_q.size() < N_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                push_encode(random_value());
            end else if (r < 8) begin
                codec_sb.encode_bytes(random_value(), seq);
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, seq.size() - 1) : -1;
                foreach (seq[k]) begin
                    if (k == cut) begin
                        push_encode(random_value());
                    end
                    push_decode(seq[k]);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_decode(8'($urandom));
                end
            end
        end
    endtask

    task automatic send_item(input svc_pkg::t_in_item it);
        if (pacing_on && !sink_holding && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        codec_sb.note_input(it);
    endtask

    initial begin : stimulus
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        build_stimulus();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (stim_q[k]) begin
            pacing_on = (k < stim_q.size() - TAIL_ITEMS);
            if (k == n_directed + 20) begin
                hold_req = 1'b1;
            end
            send_item(stim_q[k]);
        end
        i_valid <= 1'b0;
        while (codec_sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (codec_sb.mismatches == 0 && codec_sb.expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : sink_pacing
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // Long hold-off so that the queue fills and the input stalls.
                hold_req     = 1'b0;
                sink_holding = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_holding = 1'b0;
                i_stall <= 1'b0;
            end else if (pacing_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            codec_sb.check_result(o_item);
        end
    end

    initial begin : watchdog
        #500_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: signed_varint_codec.f
hdl/svc_pkg.sv
hdl/svc_front.sv
hdl/svc_queue.sv
hdl/svc_back.sv
hdl/signed_varint_codec.sv
tb/sv/signed_varint_codec_tb.sv
